// ===== src/sepq_pkg.sv =====
// Shared types and codes for the sorted expiry priority queue.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sepq_pkg;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_POP_HEAD = 2'd1,
      OP_POP_TAIL = 2'd2,
      OP_REMOVE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_WALK,
      S_SCAN,
      S_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] id;
      logic [19:0] expiry;
      logic [31:0] payload;
   } entry_type;

   typedef struct packed {
      op_type      req_type;
      logic [15:0] item_id;
      logic [19:0] item_expiry;
      logic [31:0] item_payload;
   } req_word_type;

   typedef struct packed {
      logic [15:0] out_id;
      logic [19:0] out_expiry;
      logic [31:0] out_payload;
      status_type  status;
      logic [5:0]  count;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== src/sepq_mem.sv =====
// Slot storage: one write port, one read port, registered read data.
// Depends on sepq_pkg for the entry layout.
`timescale 1ns / 1ps
`default_nettype none

module sepq_mem import sepq_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type          rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

`ifndef SYNTHESIS
   // shifting never reads the slot being overwritten in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("read and write hit the same slot");
`endif

endmodule

`default_nettype wire

// ===== src/sepq_ctrl.sv =====
// Request sequencer: sorted insert walk, head/tail/id scan and gap-closing shift.
// Depends on sepq_pkg; drives the ports of sepq_mem.
`timescale 1ns / 1ps
`default_nettype none

module sepq_ctrl import sepq_pkg::*; #(
   parameter int DEPTH = 32,
   parameter int CW    = 6,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire req_word_type  req,
   input  wire logic [5:0]    max_entries,
   input  wire logic          out_free,
   output logic               idle,
   output logic               done,
   output rsp_word_type       rsp,
   output logic               wr_en,
   output logic [AW-1:0]      wr_addr,
   output entry_type          wr_data,
   output logic               rd_en,
   output logic [AW-1:0]      rd_addr,
   input  wire entry_type     rd_data
);

   localparam int WW = CW + 6;
   localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [CW-1:0] idx_ff, idx_in;
   entry_type    ent_ff, ent_in;
   status_type   stat_ff, stat_in;

   logic [WW-1:0] max_w, cap_w, occ_w;
   logic          full;
   logic          rd_want;
   logic [CW-1:0] rd_idx;
   logic [CW-1:0] wr_idx;
   logic [CW-1:0] idx_plus1;
   logic          hit;
   entry_type     new_ent;

   // capacity in use: zero acts as one, anything above the built depth clamps
   assign max_w = WW'(max_entries);
   assign occ_w = WW'(occ_ff);
   always_comb begin
      if (max_w == '0) begin
         cap_w = WW'(1);
      end else if (max_w > DEPTH_W) begin
         cap_w = DEPTH_W;
      end else begin
         cap_w = max_w;
      end
   end
   assign full = (occ_w >= cap_w);

   assign idx_plus1 = idx_ff + 1'b1;
   assign hit = (req_ff.req_type != OP_REMOVE) || (rd_data.id == req_ff.item_id);
   assign new_ent = '{id: req_ff.item_id, expiry: req_ff.item_expiry,
                      payload: req_ff.item_payload};

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      occ_in   = occ_ff;
      idx_in   = idx_ff;
      ent_in   = ent_ff;
      stat_in  = stat_ff;
      rd_want  = 1'b0;
      rd_idx   = idx_ff;
      wr_en    = 1'b0;
      wr_idx   = idx_ff;
      wr_data  = rd_data;
      done     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in  = req;
               ent_in  = '0;
               stat_in = ST_OK;
               if (req.req_type == OP_INSERT) begin
                  if (full) begin
                     stat_in  = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     // walk down from the free slot at the tail
                     idx_in   = occ_ff;
                     rd_want  = (occ_ff != '0);
                     rd_idx   = occ_ff - 1'b1;
                     state_in = S_INS_WALK;
                  end
               end else if (occ_ff == '0) begin
                  stat_in  = ST_EMPTY;
                  state_in = S_RESP;
               end else begin
                  rd_want  = 1'b1;
                  state_in = S_SCAN;
                  if (req.req_type == OP_POP_TAIL) begin
                     idx_in = occ_ff - 1'b1;
                     rd_idx = occ_ff - 1'b1;
                  end else begin
                     idx_in = '0;
                     rd_idx = '0;
                  end
               end
            end
         end

         S_INS_WALK: begin
            // rd_data holds slot idx-1; equal keys stay ahead of the new word
            wr_en  = 1'b1;
            wr_idx = idx_ff;
            if ((idx_ff != '0) && (req_ff.item_expiry < rd_data.expiry)) begin
               wr_data = rd_data;
               idx_in  = idx_ff - 1'b1;
               rd_want = (idx_ff > CW'(1));
               rd_idx  = idx_ff - 1'b1 - 1'b1;
            end else begin
               wr_data  = new_ent;
               occ_in   = occ_ff + 1'b1;
               state_in = S_RESP;
            end
         end

         S_SCAN: begin
            // rd_data holds slot idx; next slot is fetched ahead
            rd_want = 1'b1;
            rd_idx  = idx_plus1;
            if (hit) begin
               ent_in   = rd_data;
               state_in = S_SHIFT;
            end else if (idx_plus1 == occ_ff) begin
               stat_in  = ST_NOTFOUND;
               state_in = S_RESP;
            end else begin
               idx_in = idx_plus1;
            end
         end

         S_SHIFT: begin
            // rd_data holds slot idx+1 while it is below occupancy
            if (idx_plus1 < occ_ff) begin
               wr_en   = 1'b1;
               wr_idx  = idx_ff;
               wr_data = rd_data;
               idx_in  = idx_plus1;
               rd_want = 1'b1;
               rd_idx  = idx_plus1 + 1'b1;
            end else begin
               occ_in   = occ_ff - 1'b1;
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            done = out_free;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rd_en   = rd_want && (rd_idx < DEPTH_C);
   assign rd_addr = rd_idx[AW-1:0];
   assign wr_addr = wr_idx[AW-1:0];
   assign idle    = (state_ff == S_IDLE);

   assign rsp.out_id      = ent_ff.id;
   assign rsp.out_expiry  = ent_ff.expiry;
   assign rsp.out_payload = ent_ff.payload;
   assign rsp.status      = stat_ff;
   assign rsp.count       = occ_w[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      ent_ff  <= ent_in;
      stat_ff <= stat_in;
   end

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_C)
      else $error("occupancy above built depth");

   a_wr_only_walking: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_INS_WALK || state_ff == S_SHIFT))
      else $error("slot write outside insert walk or shift");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff != S_IDLE))
      else $error("accepted request did not start");
`endif

endmodule

`default_nettype wire

// ===== src/sorted_expiry_priority_queue.sv =====
// Sorted expiry priority queue: insert walks down, removal scans then shifts,
// one slot per cycle, before the response word is queued.
// One request in flight; with the output free a new request is taken the cycle
// after the response word is queued.
// Synchronous active-high reset empties the queue and sets max_entries to
// the built depth (at most 63); slot storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_expiry_priority_queue import sepq_pkg::*; #(
   parameter int DEPTH = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_data,
   input  wire logic         csr_wr_en,
   input  wire logic [5:0]   csr_wr_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [5:0] CAP_RESET = (DEPTH > 63) ? 6'd63 : 6'(DEPTH);

   logic [5:0]   max_entries_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_data_ff;

   logic          start, idle, done, out_free;
   rsp_word_type  ctrl_rsp;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd_data;

   assign req_ready = idle;
   assign start     = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   sepq_ctrl #(.DEPTH(DEPTH), .CW(CW), .AW(AW)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req_data),
      .max_entries (max_entries_ff),
      .out_free    (out_free),
      .idle        (idle),
      .done        (done),
      .rsp         (ctrl_rsp),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   sepq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= CAP_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_entries_ff <= csr_wr_data;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= ctrl_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
